FILE: hw/rtl/blal_pkg.sv
package blal_pkg;

  // default list depth
  localparam int unsigned CAPACITY_DEF = 16;

  // beat field widths
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 5;

  // tdata widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 4'd0,
    CMD_INS_BACK  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_DEL_FRONT = 4'd3,
    CMD_DEL_BACK  = 4'd4,
    CMD_DEL_AT    = 4'd5,
    CMD_ROT_LEFT  = 4'd6,
    CMD_ROT_RIGHT = 4'd7,
    CMD_SORT      = 4'd8,
    CMD_READ_AT   = 4'd9
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SORT,
    S_SORT_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sort_start;
    logic sort_step;
    logic sort_finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sort;
    logic sort_needed;
    logic sort_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/blal_ctrl.sv
module blal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  blal_pkg::dp_stat_t stat,
  output blal_pkg::dp_cmd_t  ctl
);

  blal_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             load;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blal_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      blal_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = blal_pkg::S_EXEC;
        end
      end
      blal_pkg::S_EXEC: begin
        if (stat.is_sort && stat.sort_needed) begin
          ctl.sort_start = 1'b1;
          state_nxt      = blal_pkg::S_SORT;
        end else if (slot_free) begin
          ctl.exec  = 1'b1;
          load      = 1'b1;
          state_nxt = blal_pkg::S_IDLE;
        end
      end
      blal_pkg::S_SORT: begin
        ctl.sort_step = 1'b1;
        if (stat.sort_last) begin
          state_nxt = blal_pkg::S_SORT_DONE;
        end
      end
      blal_pkg::S_SORT_DONE: begin
        if (slot_free) begin
          ctl.sort_finish = 1'b1;
          load            = 1'b1;
          state_nxt       = blal_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = blal_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/blal_dp.sv
module blal_dp #(
  parameter int unsigned CAPACITY = blal_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  blal_pkg::dp_cmd_t                    ctl,
  output blal_pkg::dp_stat_t                   stat,
  input  logic [blal_pkg::CMD_W-1:0]           cmd_in,
  input  logic [blal_pkg::POS_W-1:0]           pos_in,
  input  logic signed [blal_pkg::VAL_W-1:0]    val_in,
  output logic [blal_pkg::STAT_W-1:0]          status_out,
  output logic signed [blal_pkg::VAL_W-1:0]    element_out,
  output logic [blal_pkg::CNT_OUT_W-1:0]       count_out
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > blal_pkg::POS_W) ? CW : blal_pkg::POS_W;
  localparam int unsigned XW = (CW > blal_pkg::CNT_OUT_W) ? CW : blal_pkg::CNT_OUT_W;

  logic [blal_pkg::CMD_W-1:0]        cmd_r;
  logic [blal_pkg::POS_W-1:0]        pos_r;
  logic signed [blal_pkg::VAL_W-1:0] val_r;

  logic signed [blal_pkg::VAL_W-1:0] cells_r   [CAPACITY];
  logic signed [blal_pkg::VAL_W-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     phase_r;

  logic [blal_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic signed [blal_pkg::VAL_W-1:0] elem_r, elem_nxt;
  logic [blal_pkg::CNT_OUT_W-1:0]    cnt_out_r;
  logic [XW-1:0]                     cnt_x;

  logic ins_op, del_op, rd_op, rotl_op, rotr_op;
  logic full, empty, bad_ins, bad_del, ins_ok, del_ok, rot_ok;
  logic [MW-1:0] pos_x, cnt_x_cmp;
  logic [IW-1:0] ins_idx, rd_idx, last_idx;
  logic signed [blal_pkg::VAL_W-1:0] rd_data;

  // command decode
  always_comb begin
    ins_op  = 1'b0;
    del_op  = 1'b0;
    rd_op   = 1'b0;
    rotl_op = 1'b0;
    rotr_op = 1'b0;
    case (cmd_r) inside
      blal_pkg::CMD_INS_FRONT, blal_pkg::CMD_INS_BACK, blal_pkg::CMD_INS_AT: ins_op = 1'b1;
      blal_pkg::CMD_DEL_FRONT, blal_pkg::CMD_DEL_BACK, blal_pkg::CMD_DEL_AT: del_op = 1'b1;
      blal_pkg::CMD_READ_AT:   rd_op   = 1'b1;
      blal_pkg::CMD_ROT_LEFT:  rotl_op = 1'b1;
      blal_pkg::CMD_ROT_RIGHT: rotr_op = 1'b1;
      default: ;
    endcase
  end

  assign pos_x     = MW'(pos_r);
  assign cnt_x_cmp = MW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign bad_ins   = (cmd_r == blal_pkg::CMD_INS_AT) && (pos_x > cnt_x_cmp);
  assign bad_del   = ((cmd_r == blal_pkg::CMD_DEL_AT) || (cmd_r == blal_pkg::CMD_READ_AT))
                     && (pos_x >= cnt_x_cmp);
  assign ins_ok    = ins_op && !full && !bad_ins;
  assign del_ok    = (del_op || rd_op) && !empty && !bad_del;
  assign rot_ok    = (count_r > CW'(1));
  assign last_idx  = IW'(count_r - CW'(1));

  always_comb begin
    case (cmd_r)
      blal_pkg::CMD_INS_FRONT: ins_idx = '0;
      blal_pkg::CMD_INS_BACK:  ins_idx = IW'(count_r);
      default:                 ins_idx = IW'(pos_r);
    endcase
  end

  always_comb begin
    case (cmd_r) inside
      blal_pkg::CMD_DEL_FRONT:                          rd_idx = '0;
      blal_pkg::CMD_DEL_BACK, blal_pkg::CMD_ROT_RIGHT:  rd_idx = last_idx;
      default:                                          rd_idx = IW'(pos_r);
    endcase
  end

  // single read port: read, remove, rotate right
  assign rd_data = cells_r[rd_idx];

  // result fields
  always_comb begin
    status_nxt = blal_pkg::ST_OK;
    elem_nxt   = '0;
    count_nxt  = count_r;
    if (ins_op) begin
      if (full) begin
        status_nxt = blal_pkg::ST_FULL;
      end else if (bad_ins) begin
        status_nxt = blal_pkg::ST_BADPOS;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (del_op || rd_op) begin
      if (empty) begin
        status_nxt = blal_pkg::ST_EMPTY;
        elem_nxt   = '1;
      end else if (bad_del) begin
        status_nxt = blal_pkg::ST_BADPOS;
        elem_nxt   = '1;
      end else begin
        elem_nxt = rd_data;
        if (del_op) begin
          count_nxt = count_r - CW'(1);
        end
      end
    end
  end

  // cell row update: shifts and rotates in one beat, sort one phase per cycle
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (ctl.exec) begin
        if (ins_ok) begin
          if (IW'(i) == ins_idx) begin
            cells_nxt[i] = val_r;
          end else if ((i > 0) && (IW'(i) > ins_idx)) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end
        end else if (del_op && del_ok) begin
          if ((i < CAPACITY - 1) && (IW'(i) >= rd_idx)) begin
            cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end else if (rotl_op && rot_ok) begin
          if (IW'(i) == last_idx) begin
            cells_nxt[i] = cells_r[0];
          end else if ((i < CAPACITY - 1) && (IW'(i) < last_idx)) begin
            cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end else if (rotr_op && rot_ok) begin
          if (i == 0) begin
            cells_nxt[i] = rd_data;
          end else if (IW'(i) <= last_idx) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
    // odd-even transposition: pairs of one parity per phase
    if (ctl.sort_step) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if ((j[0] == phase_r[0]) && (CW'(j + 1) < count_r)
            && (cells_r[j] > cells_r[j + 1])) begin
          cells_nxt[j]     = cells_r[j + 1];
          cells_nxt[j + 1] = cells_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_in;
      pos_r <= pos_in;
      val_r <= val_in;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
    end else begin
      if (ctl.exec) begin
        count_r <= count_nxt;
      end
      if (ctl.sort_start) begin
        phase_r <= '0;
      end else if (ctl.sort_step) begin
        phase_r <= phase_r + CW'(1);
      end
    end
  end

  // count field is taken modulo 32
  assign cnt_x = ctl.exec ? XW'(count_nxt) : XW'(count_r);

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_r  <= status_nxt;
      elem_r    <= elem_nxt;
      cnt_out_r <= cnt_x[blal_pkg::CNT_OUT_W-1:0];
    end else if (ctl.sort_finish) begin
      status_r  <= blal_pkg::ST_OK;
      elem_r    <= '0;
      cnt_out_r <= cnt_x[blal_pkg::CNT_OUT_W-1:0];
    end
  end

  assign stat.is_sort     = (cmd_r == blal_pkg::CMD_SORT);
  assign stat.sort_needed = rot_ok;
  assign stat.sort_last   = (phase_r == (count_r - CW'(1)));

  assign status_out  = status_r;
  assign element_out = elem_r;
  assign count_out   = cnt_out_r;

endmodule

FILE: hw/rtl/bounded_array_list_engine.sv
// An input beat is captured in the command register and executed into the
// result register; a sort of two or more elements first runs one odd-even
// compare-exchange phase per cycle. A command is taken only after the last
// has executed; a waiting result holds up only execution, not acceptance.
// Reset: synchronous, active-low rst_n empties the list; element cells keep
// whatever they hold and are never read before being written.
module bounded_array_list_engine #(
  parameter int unsigned CAPACITY = blal_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input beat
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [3:0] command, [7:4] position, [39:8] value
  input  logic [blal_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result beat
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [1:0] status, [33:2] element, [38:34] count, [39] zero
  output logic [blal_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int unsigned POS_LO = blal_pkg::CMD_W;
  localparam int unsigned VAL_LO = POS_LO + blal_pkg::POS_W;
  localparam int unsigned OUT_USED = blal_pkg::STAT_W + blal_pkg::VAL_W
                                     + blal_pkg::CNT_OUT_W;

  blal_pkg::dp_cmd_t  ctl;
  blal_pkg::dp_stat_t stat;

  logic [blal_pkg::STAT_W-1:0]       status;
  logic signed [blal_pkg::VAL_W-1:0] element;
  logic [blal_pkg::CNT_OUT_W-1:0]    count;

  // sequencer: accept, execute or run the sort phases, hand over result
  blal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // element row, fill count, command register and result register
  blal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .cmd_in      (in_tdata[POS_LO-1:0]),
    .pos_in      (in_tdata[VAL_LO-1:POS_LO]),
    .val_in      (in_tdata[VAL_LO+blal_pkg::VAL_W-1:VAL_LO]),
    .status_out  (status),
    .element_out (element),
    .count_out   (count)
  );

  // pack result beat, pad bits tied low
  assign out_tdata = {{(blal_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, count, element, status};

endmodule

FILE: hw/rtl/blal_checker.sv
module blal_checker #(
  parameter int unsigned CAPACITY = blal_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [blal_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [blal_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // one command in flight: no further beat taken right after one is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while previous command still executing");

  // a result never appears on the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared without execution cycle");

  // full status only with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == blal_pkg::ST_FULL))
    |-> (out_tdata[38:34] == 5'(CAPACITY)))
    else $error("full status with list not at capacity");

  // empty status only with an empty list and element all ones
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == blal_pkg::ST_EMPTY))
    |-> ((out_tdata[38:34] == 5'd0) && (out_tdata[33:2] == 32'hFFFF_FFFF)))
    else $error("empty status with non-empty list or bad element");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind bounded_array_list_engine blal_checker #(
  .CAPACITY (CAPACITY)
) u_blal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
